// ===== sv/ssp_pkg.sv =====
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int VID_W      = 5;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 32;
  localparam int VCOUNT_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [VID_W-1:0]           tail;
    logic [VID_W-1:0]           head;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

endpackage

// ===== sv/single_source_shortest_paths.sv =====
`timescale 1ns / 1ps

// Bellman-Ford shortest paths. Edges are loaded one per cycle while in_stall is
// low into an edge memory; the transaction with in_last_edge set starts a run.
// It makes n-1 relaxation rounds (n = vertex_count clamped to 1..MAX_VERTEX)
// plus one negative-cycle check pass over the stored edges, all through one
// shared add/saturate/compare unit that steps each edge through the edge read,
// tail read, head read, calc and update states, since the distance table is a
// single-read-port memory read once for the tail and once for the head. Each
// vertex result is then held on the output while out_stall is high (a
// negative cycle gives one result as soon as it is seen). in_stall is high from
// the start of the run until the last result transaction completes.
module single_source_shortest_paths
  import ssp_pkg::*;
#(
  parameter int MAX_VERTEX = 32,
  parameter int MAX_EDGE   = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [VID_W-1:0]           in_edge_from,
  input  logic [VID_W-1:0]           in_edge_to,
  input  logic signed [WEIGHT_W-1:0] in_edge_weight,
  input  logic                       in_last_edge,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [VID_W-1:0]           out_vertex_id,
  output logic                       out_reachable,
  output logic signed [DIST_W-1:0]   out_distance,
  output logic                       out_has_predecessor,
  output logic [VID_W-1:0]           out_predecessor,
  output logic                       out_negative_cycle,
  output logic                       out_last_result
);

  localparam int VX_W  = $clog2(MAX_VERTEX);
  localparam int N_W   = $clog2(MAX_VERTEX + 1);
  localparam int CW    = (N_W > VCOUNT_W) ? N_W : VCOUNT_W;
  localparam int ET_W  = $clog2(MAX_EDGE + 1);
  localparam int EA_W  = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
  localparam int DRAM_W = VX_W + DIST_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_EDGE_RD  = 4'd2;
  localparam logic [3:0] S_TAIL_RD  = 4'd3;
  localparam logic [3:0] S_HEAD_RD  = 4'd4;
  localparam logic [3:0] S_CALC     = 4'd5;
  localparam logic [3:0] S_UPD      = 4'd6;
  localparam logic [3:0] S_OUT_RD   = 4'd7;
  localparam logic [3:0] S_OUT_LOAD = 4'd8;
  localparam logic [3:0] S_OUT_HOLD = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [VCOUNT_W-1:0]   vcount_r, vcount_nxt;
  logic [VID_W-1:0]      source_r, source_nxt;
  logic [ET_W-1:0]       edge_total_r, edge_total_nxt;
  logic [ET_W-1:0]       e_r, e_nxt;
  logic [N_W-1:0]        n_r, n_nxt;
  logic [N_W-1:0]        k_r, k_nxt;
  logic [VX_W-1:0]       i_r, i_nxt;
  logic                  check_r, check_nxt;
  logic                  src_ok_r, src_ok_nxt;
  logic [MAX_VERTEX-1:0] dvalid_r, dvalid_nxt;
  logic [MAX_VERTEX-1:0] pvalid_r, pvalid_nxt;
  edge_t                 edge_r, edge_nxt;
  logic signed [DIST_W-1:0] dtail_r, dtail_nxt;
  logic signed [DIST_W-1:0] dhead_r, dhead_nxt;
  logic signed [DIST_W-1:0] cand_r, cand_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VID_W-1:0]      o_vid_r, o_vid_nxt;
  logic                  o_reach_r, o_reach_nxt;
  logic signed [DIST_W-1:0] o_dist_r, o_dist_nxt;
  logic                  o_hasp_r, o_hasp_nxt;
  logic [VID_W-1:0]      o_pred_r, o_pred_nxt;
  logic                  o_neg_r, o_neg_nxt;
  logic                  o_last_r, o_last_nxt;

  // edge memory
  logic                  eram_we;
  logic [EA_W-1:0]       eram_waddr;
  edge_t                 eram_wdata;
  logic [EA_W-1:0]       eram_raddr;
  logic [EDGE_W-1:0]     eram_rdata;

  // distance memory: {predecessor, distance}
  logic                  dram_we;
  logic [VX_W-1:0]       dram_waddr;
  logic [DRAM_W-1:0]     dram_wdata;
  logic [VX_W-1:0]       dram_raddr;
  logic [DRAM_W-1:0]     dram_rdata;

  ssp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGE)) u_edge_ram (
    .clk   (clk),
    .we    (eram_we),
    .waddr (eram_waddr),
    .wdata (eram_wdata),
    .raddr (eram_raddr),
    .rdata (eram_rdata)
  );

  ssp_ram #(.WIDTH(DRAM_W), .DEPTH(MAX_VERTEX)) u_dist_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .raddr (dram_raddr),
    .rdata (dram_rdata)
  );

  logic                  in_acc;
  logic [N_W-1:0]        n_clamp;
  logic                  store_room;
  edge_t                 edge_rd;
  logic [VX_W-1:0]       tail_ix, head_ix;
  logic                  edge_in_range;
  logic                  improve;
  logic                  edge_done;
  logic signed [DIST_W:0] sum;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign edge_rd  = edge_t'(eram_rdata);
  assign tail_ix  = VX_W'(edge_r.tail);
  assign head_ix  = VX_W'(edge_r.head);
  assign store_room = (edge_total_r < ET_W'(MAX_EDGE));

  assign edge_in_range = (CW'(edge_r.tail) < CW'(n_r)) && (CW'(edge_r.head) < CW'(n_r));
  // strict improvement; anything finite beats an unreached head
  assign improve   = edge_in_range && dvalid_r[tail_ix] &&
                     (!dvalid_r[head_ix] || (dhead_r > cand_r));
  assign edge_done = ((e_r + ET_W'(1)) == edge_total_r);

  assign sum = {dtail_r[DIST_W-1], dtail_r} +
               (DIST_W + 1)'(edge_r.weight);

  always_comb begin
    if (vcount_r == '0) begin
      n_clamp = N_W'(1);
    end else if (CW'(vcount_r) > CW'(MAX_VERTEX)) begin
      n_clamp = N_W'(MAX_VERTEX);
    end else begin
      n_clamp = N_W'(vcount_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    source_nxt     = source_r;
    edge_total_nxt = edge_total_r;
    e_nxt          = e_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    check_nxt      = check_r;
    src_ok_nxt     = src_ok_r;
    dvalid_nxt     = dvalid_r;
    pvalid_nxt     = pvalid_r;
    edge_nxt       = edge_r;
    dtail_nxt      = dtail_r;
    dhead_nxt      = dhead_r;
    cand_nxt       = cand_r;
    out_valid_nxt  = out_valid_r;
    o_vid_nxt      = o_vid_r;
    o_reach_nxt    = o_reach_r;
    o_dist_nxt     = o_dist_r;
    o_hasp_nxt     = o_hasp_r;
    o_pred_nxt     = o_pred_r;
    o_neg_nxt      = o_neg_r;
    o_last_nxt     = o_last_r;

    eram_we    = 1'b0;
    eram_waddr = edge_total_r[EA_W-1:0];
    eram_wdata = '{tail: in_edge_from, head: in_edge_to, weight: in_edge_weight};
    eram_raddr = e_r[EA_W-1:0];
    dram_we    = 1'b0;
    dram_waddr = head_ix;
    dram_wdata = {tail_ix, cand_r};
    dram_raddr = i_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT:  vcount_nxt = cfg_data;
        REG_SOURCE_VERTEX: source_nxt = cfg_data[VID_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (store_room) begin
            eram_we        = 1'b1;
            edge_total_nxt = edge_total_r + ET_W'(1);
          end
          if (in_last_edge) begin
            n_nxt      = n_clamp;
            src_ok_nxt = (CW'(source_r) < CW'(n_clamp));
            dvalid_nxt = '0;
            pvalid_nxt = '0;
            if (CW'(source_r) < CW'(n_clamp)) begin
              dvalid_nxt[VX_W'(source_r)] = 1'b1;
            end
            e_nxt     = '0;
            k_nxt     = '0;
            i_nxt     = '0;
            check_nxt = (n_clamp == N_W'(1));
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        dram_we    = src_ok_r;
        dram_waddr = VX_W'(source_r);
        dram_wdata = '0;
        state_nxt  = (edge_total_r == '0) ? S_OUT_RD : S_EDGE_RD;
      end
      S_EDGE_RD: begin
        eram_raddr = e_r[EA_W-1:0];
        state_nxt  = S_TAIL_RD;
      end
      S_TAIL_RD: begin
        edge_nxt   = edge_rd;
        dram_raddr = VX_W'(edge_rd.tail);
        state_nxt  = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        dtail_nxt  = dram_rdata[DIST_W-1:0];
        dram_raddr = head_ix;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        dhead_nxt = dram_rdata[DIST_W-1:0];
        // saturate to the signed 32-bit range
        if (sum[DIST_W] != sum[DIST_W-1]) begin
          cand_nxt = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
          cand_nxt = sum[DIST_W-1:0];
        end
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (check_r) begin
          if (improve && dvalid_r[head_ix]) begin
            out_valid_nxt = 1'b1;
            o_vid_nxt     = '0;
            o_reach_nxt   = 1'b0;
            o_dist_nxt    = '0;
            o_hasp_nxt    = 1'b0;
            o_pred_nxt    = '0;
            o_neg_nxt     = 1'b1;
            o_last_nxt    = 1'b1;
            state_nxt     = S_OUT_HOLD;
          end else if (edge_done) begin
            i_nxt     = '0;
            state_nxt = S_OUT_RD;
          end else begin
            e_nxt     = e_r + ET_W'(1);
            state_nxt = S_EDGE_RD;
          end
        end else begin
          if (improve) begin
            dram_we             = 1'b1;
            dvalid_nxt[head_ix] = 1'b1;
            pvalid_nxt[head_ix] = 1'b1;
          end
          state_nxt = S_EDGE_RD;
          if (edge_done) begin
            e_nxt = '0;
            // round k just ended; n-1 rounds in all
            if ((k_r + N_W'(2)) == n_r) begin
              check_nxt = 1'b1;
            end else begin
              k_nxt = k_r + N_W'(1);
            end
          end else begin
            e_nxt = e_r + ET_W'(1);
          end
        end
      end
      S_OUT_RD: begin
        dram_raddr = i_r;
        state_nxt  = S_OUT_LOAD;
      end
      S_OUT_LOAD: begin
        out_valid_nxt = 1'b1;
        o_vid_nxt     = VID_W'(i_r);
        o_reach_nxt   = dvalid_r[i_r];
        o_dist_nxt    = dvalid_r[i_r] ? dram_rdata[DIST_W-1:0] : '0;
        o_hasp_nxt    = pvalid_r[i_r];
        o_pred_nxt    = pvalid_r[i_r] ? VID_W'(dram_rdata[DRAM_W-1:DIST_W]) : '0;
        o_neg_nxt     = 1'b0;
        o_last_nxt    = ((N_W'(i_r) + N_W'(1)) == n_r);
        state_nxt     = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            edge_total_nxt = '0;
            state_nxt      = S_IDLE;
          end else begin
            i_nxt     = i_r + VX_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vcount_r     <= VCOUNT_RESET;
      source_r     <= '0;
      edge_total_r <= '0;
      e_r          <= '0;
      n_r          <= '0;
      k_r          <= '0;
      i_r          <= '0;
      check_r      <= 1'b0;
      src_ok_r     <= 1'b0;
      dvalid_r     <= '0;
      pvalid_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      source_r     <= source_nxt;
      edge_total_r <= edge_total_nxt;
      e_r          <= e_nxt;
      n_r          <= n_nxt;
      k_r          <= k_nxt;
      i_r          <= i_nxt;
      check_r      <= check_nxt;
      src_ok_r     <= src_ok_nxt;
      dvalid_r     <= dvalid_nxt;
      pvalid_r     <= pvalid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_r    <= edge_nxt;
    dtail_r   <= dtail_nxt;
    dhead_r   <= dhead_nxt;
    cand_r    <= cand_nxt;
    o_vid_r   <= o_vid_nxt;
    o_reach_r <= o_reach_nxt;
    o_dist_r  <= o_dist_nxt;
    o_hasp_r  <= o_hasp_nxt;
    o_pred_r  <= o_pred_nxt;
    o_neg_r   <= o_neg_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_vertex_id       = o_vid_r;
  assign out_reachable       = o_reach_r;
  assign out_distance        = o_dist_r;
  assign out_has_predecessor = o_hasp_r;
  assign out_predecessor     = o_pred_r;
  assign out_negative_cycle  = o_neg_r;
  assign out_last_result     = o_last_r;

endmodule

// ===== sv/ssp_ram.sv =====
`timescale 1ns / 1ps

module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
